>>> hw/rtl/pbe_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the packbits encoder
// used by the datapath, the controller and the top level; no dependencies

package pbe_pkg;

    localparam int MAX_LITERAL = 32;
    localparam int LIT_CNT_W   = $clog2(MAX_LITERAL + 1);
    localparam int LIT_IDX_W   = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam int              RUN_CAP     = 128;
    localparam logic [8:0]      RUN_BASE    = 9'd257;
    localparam logic [7:0]      RUN_CAP_HDR = 8'(RUN_BASE - 9'(RUN_CAP));
    localparam logic [7:0]      END_MARK    = 8'd128;
    localparam logic [7:0]      RUN_START   = 8'd2;

    // what goes into the output register
    typedef enum logic [2:0] {
        SRC_RUN_HDR,
        SRC_RUN_VAL,
        SRC_LIT_HDR,
        SRC_LIT_BYTE,
        SRC_TERM
    } src_t;

    typedef struct packed {
        logic step;
        logic load_final;
        logic emit;
        src_t emit_src;
        logic emit_last;
        logic rd_start;
        logic rd_next;
    } cmd_t;

    typedef struct packed {
        logic run_pend;
        logic lit_pend;
        logic item_last;
        logic lit_final;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/pbe_in_if.sv
`timescale 1ns / 1ps
// input channel of the packbits encoder: one raw byte per word
// no dependencies

interface pbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

>>> hw/rtl/pbe_out_if.sv
`timescale 1ns / 1ps
// output channel of the packbits encoder: one code byte per word
// no dependencies

interface pbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_burst;
    logic       is_terminator;

    modport source (output valid, output out_byte, output last_of_burst,
                    output is_terminator, input ready);
    modport sink   (input valid, input out_byte, input last_of_burst,
                    input is_terminator, output ready);
endinterface

>>> hw/rtl/pbe_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module pbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/pbe_datapath.sv
`timescale 1ns / 1ps
// packbits encoder datapath: run/literal state, literal store, output register
// depends on pbe_pkg and pbe_ram

module pbe_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  logic          is_last,
    input  pbe_pkg::cmd_t cmd,
    output pbe_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          last_of_burst,
    output logic          is_terminator
);

    localparam int CW = pbe_pkg::LIT_CNT_W;
    localparam int IW = pbe_pkg::LIT_IDX_W;

    // encoder state
    logic          pv_reg,   pv_next;
    logic [7:0]    pval_reg, pval_next;
    logic [7:0]    rc_reg,   rc_next;
    logic [CW-1:0] lc_reg,   lc_next;
    // emission plan for the current word
    logic          run_pend_reg, run_pend_next;
    logic [7:0]    run_hdr_reg,  run_hdr_next;
    logic [7:0]    run_val_reg,  run_val_next;
    logic [CW-1:0] lit_n_reg,    lit_n_next;
    logic          item_last_reg, item_last_next;
    logic [IW-1:0] ptr_reg,      ptr_next;
    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg,  out_byte_next;
    logic          out_last_reg,  out_last_next;
    logic          out_term_reg,  out_term_next;

    logic          eq;
    logic          in_run;
    logic [7:0]    rc_hdr;
    logic          do_append;
    logic [CW-1:0] base;
    logic [CW-1:0] new_lc;
    logic          ram_we;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign eq     = (data_byte == pval_reg);
    assign in_run = pv_reg && (rc_reg != 8'd0);
    assign rc_hdr = 8'(pbe_pkg::RUN_BASE - {1'b0, rc_reg});
    assign new_lc = base + CW'(1);

    always_comb
    begin
        pv_next        = pv_reg;
        pval_next      = pval_reg;
        rc_next        = rc_reg;
        lc_next        = lc_reg;
        run_pend_next  = run_pend_reg;
        run_hdr_next   = run_hdr_reg;
        run_val_next   = run_val_reg;
        lit_n_next     = lit_n_reg;
        item_last_next = item_last_reg;
        do_append      = 1'b0;
        base           = '0;
        ram_we         = 1'b0;

        if (cmd.step)
        begin
            item_last_next = is_last;
            run_pend_next  = 1'b0;
            lit_n_next     = '0;
            if (in_run)
            begin
                if (eq)
                begin
                    if (rc_reg == 8'(pbe_pkg::RUN_CAP - 1))
                    begin
                        // run hits its cap: goes out whole, nothing pending
                        run_pend_next = 1'b1;
                        run_hdr_next  = pbe_pkg::RUN_CAP_HDR;
                        run_val_next  = pval_reg;
                        pv_next       = 1'b0;
                        rc_next       = 8'd0;
                        lc_next       = '0;
                    end
                    else
                    begin
                        rc_next = rc_reg + 8'd1;
                    end
                end
                else
                begin
                    run_pend_next = 1'b1;
                    run_hdr_next  = rc_hdr;
                    run_val_next  = pval_reg;
                    do_append     = 1'b1;
                end
            end
            else if (pv_reg && (lc_reg != '0) && eq)
            begin
                // repeat begins: earlier literals go out, pending byte starts a run
                lit_n_next = lc_reg - CW'(1);
                lc_next    = '0;
                rc_next    = pbe_pkg::RUN_START;
            end
            else
            begin
                do_append = 1'b1;
                base      = pv_reg ? lc_reg : '0;
            end

            if (do_append)
            begin
                ram_we    = 1'b1;
                pv_next   = 1'b1;
                pval_next = data_byte;
                rc_next   = 8'd0;
                if (new_lc == CW'(pbe_pkg::MAX_LITERAL))
                begin
                    // store full: whole group goes out, nothing pending
                    lit_n_next = new_lc;
                    lc_next    = '0;
                    pv_next    = 1'b0;
                end
                else
                begin
                    lc_next = new_lc;
                end
            end
        end

        if (cmd.load_final)
        begin
            run_pend_next = in_run;
            run_hdr_next  = rc_hdr;
            run_val_next  = pval_reg;
            lit_n_next    = in_run ? '0 : lc_reg;
            pv_next       = 1'b0;
            pval_next     = 8'd0;
            rc_next       = 8'd0;
            lc_next       = '0;
        end
    end

    // literal readout, one byte ahead of the output register
    assign ram_re    = cmd.rd_start || cmd.rd_next;
    assign ram_raddr = cmd.rd_start ? '0 : ptr_reg + IW'(1);

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ram_re)
        begin
            ptr_next = ram_raddr;
        end
    end

    pbe_ram #(
        .WIDTH (8),
        .DEPTH (pbe_pkg::MAX_LITERAL)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (base[IW-1:0]),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_term_next  = out_term_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.emit_last;
            out_term_next  = (cmd.emit_src == pbe_pkg::SRC_TERM);
            case (cmd.emit_src)
                pbe_pkg::SRC_RUN_HDR:  out_byte_next = run_hdr_reg;
                pbe_pkg::SRC_RUN_VAL:  out_byte_next = run_val_reg;
                pbe_pkg::SRC_LIT_HDR:  out_byte_next = 8'(lit_n_reg) - 8'd1;
                pbe_pkg::SRC_LIT_BYTE: out_byte_next = ram_rdata;
                pbe_pkg::SRC_TERM:     out_byte_next = pbe_pkg::END_MARK;
                default:               out_byte_next = out_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= 1'b0;
            pval_reg      <= 8'd0;
            rc_reg        <= 8'd0;
            lc_reg        <= '0;
            run_pend_reg  <= 1'b0;
            lit_n_reg     <= '0;
            item_last_reg <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg        <= pv_next;
            pval_reg      <= pval_next;
            rc_reg        <= rc_next;
            lc_reg        <= lc_next;
            run_pend_reg  <= run_pend_next;
            lit_n_reg     <= lit_n_next;
            item_last_reg <= item_last_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_hdr_reg  <= run_hdr_next;
        run_val_reg  <= run_val_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_term_reg <= out_term_next;
    end

    assign sts.run_pend  = run_pend_reg;
    assign sts.lit_pend  = (lit_n_reg != '0);
    assign sts.item_last = item_last_reg;
    assign sts.lit_final = ((CW'(ptr_reg) + CW'(1)) == lit_n_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_burst = out_last_reg;
    assign is_terminator = out_term_reg;

endmodule

>>> hw/rtl/pbe_ctrl.sv
`timescale 1ns / 1ps
// packbits encoder controller: sequences runs, literal groups and the terminator
// depends on pbe_pkg

module pbe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pbe_pkg::sts_t sts,
    output pbe_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_RUN_HDR,
        S_RUN_VAL,
        S_LIT_HDR,
        S_LIT_BYTE,
        S_FIN,
        S_TERM
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg,   fin_next;
    state_t after_lit;

    // where to go once the literal part of a plan is done
    always_comb
    begin
        if (fin_reg)
        begin
            after_lit = S_TERM;
        end
        else if (sts.item_last)
        begin
            after_lit = S_FIN;
        end
        else
        begin
            after_lit = S_IDLE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        in_ready       = 1'b0;
        cmd.step       = 1'b0;
        cmd.load_final = 1'b0;
        cmd.emit       = 1'b0;
        cmd.emit_src   = pbe_pkg::SRC_RUN_HDR;
        cmd.emit_last  = 1'b0;
        cmd.rd_start   = 1'b0;
        cmd.rd_next    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    fin_next   = 1'b0;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (sts.run_pend)
                begin
                    state_next = S_RUN_HDR;
                end
                else if (sts.lit_pend)
                begin
                    state_next = S_LIT_HDR;
                end
                else
                begin
                    state_next = after_lit;
                end
            end
            S_RUN_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = pbe_pkg::SRC_RUN_HDR;
                    state_next   = S_RUN_VAL;
                end
            end
            S_RUN_VAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = pbe_pkg::SRC_RUN_VAL;
                    cmd.emit_last = !fin_reg && !sts.item_last && !sts.lit_pend;
                    state_next    = sts.lit_pend ? S_LIT_HDR : after_lit;
                end
            end
            S_LIT_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = pbe_pkg::SRC_LIT_HDR;
                    cmd.rd_start = 1'b1;
                    state_next   = S_LIT_BYTE;
                end
            end
            S_LIT_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = pbe_pkg::SRC_LIT_BYTE;
                    cmd.emit_last = sts.lit_final && !fin_reg && !sts.item_last;
                    if (sts.lit_final)
                    begin
                        state_next = after_lit;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                // end of stream: flush whatever is pending
                cmd.load_final = 1'b1;
                fin_next       = 1'b1;
                state_next     = S_PLAN;
            end
            S_TERM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = pbe_pkg::SRC_TERM;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

>>> hw/rtl/packbits_encoder.sv
`timescale 1ns / 1ps
// packbits run-length encoder
// input word: one raw byte plus a flag on the last byte of a stream
// output word: one code byte (run header, run value, literal header, literal
//   byte or the end marker 128), flagged on the last byte caused by an input
//   word and on the end marker
// an input word is taken in the idle state; the encoder then plans the word's
//   code bytes (possibly none) and emits them, and the last word of a stream
//   also passes a flush state and a second plan for the end-of-stream flush;
//   while the sink is ready the single output register passes one code byte per cycle
// literal bytes are read back from a small ram one byte ahead of the output
// a literal group holds up to pbe_pkg::MAX_LITERAL bytes, a run up to 128
// when the sink stalls, the current code byte holds in the output register
//   and the encoder waits; the next input word is taken once the previous
//   word's bytes have all entered the output register
// reset clears the encoder state and the output valid flag; the literal store
//   needs no clearing since only written entries are read
// depends on pbe_pkg, pbe_in_if, pbe_out_if, pbe_ram, pbe_datapath, pbe_ctrl

module packbits_encoder (
    input  logic         clk,
    input  logic         rst_n,
    pbe_in_if.sink       in_chan,
    pbe_out_if.source    out_chan
);

    pbe_pkg::cmd_t cmd;
    pbe_pkg::sts_t sts;

    pbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_chan.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (in_chan.data_byte),
        .is_last       (in_chan.is_last),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_chan.ready),
        .out_valid     (out_chan.valid),
        .out_byte      (out_chan.out_byte),
        .last_of_burst (out_chan.last_of_burst),
        .is_terminator (out_chan.is_terminator)
    );

endmodule

>>> tb/pbe_checker.sv
`timescale 1ns / 1ps
// checker of the packbits encoder: predicts the code bytes of every input word
// and compares them, in order, with the words on the output channel
// depends on pbe_pkg, pbe_in_if and pbe_out_if

module pbe_checker (
    input  logic clk,
    input  logic rst_n,
    pbe_in_if    in_mon,
    pbe_out_if   out_mon,
    output int   errors,
    output int   backlog,
    output int   codes_seen
);

    typedef struct packed {
        logic [7:0] code;
        logic       burst_end;
        logic       term;
    } code_word_t;

    code_word_t code_q[$];

    // encoder state as predicted
    logic       hold_valid;
    logic [7:0] hold_byte;
    int         run_len;
    int         lit_len;
    logic [7:0] lit_mem [pbe_pkg::MAX_LITERAL];

    int burst_n;
    int err_cnt;
    int code_cnt;

    task automatic push_code(input logic [7:0] v, input logic term);
        code_word_t w;
        w = '{code: v, burst_end: 1'b0, term: term};
        code_q.insert(code_q.size(), w);
        burst_n++;
    endtask

    task automatic emit_literals(input int cnt);
        int n;
        n = (cnt > pbe_pkg::MAX_LITERAL) ? pbe_pkg::MAX_LITERAL : cnt;
        if (n > 0)
        begin
            push_code(8'(n - 1), 1'b0);
            for (int i = 0; i < n; i++)
                push_code(lit_mem[i], 1'b0);
        end
    endtask

    task automatic emit_run(input int copies, input logic [7:0] v);
        push_code(8'(int'(pbe_pkg::RUN_BASE) - copies), 1'b0);
        push_code(v, 1'b0);
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (lit_len < pbe_pkg::MAX_LITERAL)
        begin
            lit_mem[lit_len] = b;
            lit_len++;
        end
        hold_valid = 1'b1;
        hold_byte  = b;
        run_len    = 0;
        // a full store goes out at once, the held byte with it
        if (lit_len >= pbe_pkg::MAX_LITERAL)
        begin
            emit_literals(lit_len);
            lit_len    = 0;
            hold_valid = 1'b0;
        end
    endtask

    task automatic encode_word(input logic [7:0] b, input logic last);
        burst_n = 0;
        if (hold_valid && run_len > 0)
        begin
            if (b == hold_byte)
            begin
                run_len++;
                if (run_len >= pbe_pkg::RUN_CAP)
                begin
                    emit_run(pbe_pkg::RUN_CAP, hold_byte);
                    hold_valid = 1'b0;
                    run_len    = 0;
                    lit_len    = 0;
                end
            end
            else
            begin
                emit_run(run_len, hold_byte);
                lit_len = 0;
                take_byte(b);
            end
        end
        else if (hold_valid && lit_len > 0 && b == hold_byte)
        begin
            // repeat begins: the held byte leaves the literal group
            emit_literals(lit_len - 1);
            lit_len = 0;
            run_len = 2;
        end
        else
        begin
            if (!hold_valid)
                lit_len = 0;
            take_byte(b);
        end

        if (last)
        begin
            if (hold_valid && run_len > 0)
                emit_run(run_len, hold_byte);
            else
                emit_literals(lit_len);
            push_code(pbe_pkg::END_MARK, 1'b1);
            hold_valid = 1'b0;
            hold_byte  = 8'd0;
            run_len    = 0;
            lit_len    = 0;
        end

        if (burst_n > 0)
            code_q[code_q.size() - 1].burst_end = 1'b1;
    endtask

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        code_word_t want;
        code_word_t got;
        if (!rst_n)
        begin
            code_q.delete();
            hold_valid = 1'b0;
            hold_byte  = 8'd0;
            run_len    = 0;
            lit_len    = 0;
            err_cnt    = 0;
            code_cnt   = 0;
            errors     <= 0;
            backlog    <= 0;
            codes_seen <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                encode_word(in_mon.data_byte, in_mon.is_last);

            if (out_mon.valid && out_mon.ready)
            begin
                got = '{code: out_mon.out_byte, burst_end: out_mon.last_of_burst,
                        term: out_mon.is_terminator};
                code_cnt++;
                if (code_q.size() == 0)
                    note_error($sformatf("unexpected word byte=%02h last=%0b term=%0b",
                                         got.code, got.burst_end, got.term));
                else
                begin
                    want = code_q.pop_front();
                    if (got != want)
                        note_error($sformatf(
                            "word %0d expected byte=%02h last=%0b term=%0b, got byte=%02h last=%0b term=%0b",
                            code_cnt, want.code, want.burst_end, want.term,
                            got.code, got.burst_end, got.term));
                end
            end

            errors     <= err_cnt;
            backlog    <= code_q.size();
            codes_seen <= code_cnt;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// regression top of the packbits encoder: clock, reset, stimulus and verdict
// depends on pbe_pkg, pbe_in_if, pbe_out_if, packbits_encoder and pbe_checker

module tb;

    logic clk;
    logic rst_n;

    pbe_in_if  in_ch ();
    pbe_out_if out_ch ();

    int errors;
    int backlog;
    int codes_seen;

    bit idle_on;
    int hold_len;
    int words_sent;
    int streams_sent;

    packbits_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_ch),
        .out_chan (out_ch)
    );

    pbe_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .errors     (errors),
        .backlog    (backlog),
        .codes_seen (codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("packbits_encoder regression: fail");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin : receiver
        int n;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                n = hold_len;
                hold_len = 0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= !(idle_on && $urandom_range(99) < 24);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(99) < 24)
        begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
        if (last)
            streams_sent++;
    endtask

    task automatic send_seq(input logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_word(q[i], i == q.size() - 1);
    endtask

    // wait until the checker holds no expected word
    task automatic drain();
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // stream of runs and single literal bytes with random content
    task automatic build_mixed(ref logic [7:0] q[$], input int len, input int max_run);
        logic [7:0] b;
        int seg;
        q.delete();
        while (q.size() < len)
        begin
            b = pick_byte();
            if (q.size() > 0 && b == q[q.size() - 1])
                b = b + 8'd1;
            seg = ($urandom_range(99) < 45) ? $urandom_range(2, max_run) : 1;
            for (int k = 0; k < seg && q.size() < len; k++)
                q.insert(q.size(), b);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] seq[$];
        logic [7:0] b;
        logic [7:0] alphabet[4];

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.is_last   <= 1'b0;
        rst_n           <= 1'b0;
        idle_on         = 1'b1;
        hold_len        = 0;
        words_sent      = 0;
        streams_sent    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-byte streams, shortest run, repeat after literals,
        // byte 255 as data, last on a run and on a literal
        seq = {8'h00};                                  send_seq(seq);
        seq = {8'hff};                                  send_seq(seq);
        seq = {8'h55, 8'h55};                           send_seq(seq);
        seq = {8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04}; send_seq(seq);
        seq = {8'hff, 8'hff, 8'h00, 8'hff};             send_seq(seq);
        seq = {8'h80, 8'h7f, 8'h80};                    send_seq(seq);
        seq = {8'haa, 8'haa, 8'haa, 8'h55, 8'h55};      send_seq(seq);
        in_ch.valid <= 1'b0;
        drain();

        // long receiver hold-off while the sender keeps offering words
        hold_len = 300;
        repeat (5)
        begin
            build_mixed(seq, $urandom_range(10, 20), 8);
            send_seq(seq);
        end
        in_ch.valid <= 1'b0;
        drain();

        // stretch with no idling on either side
        idle_on = 1'b0;
        repeat (3)
        begin
            build_mixed(seq, $urandom_range(12, 24), 10);
            send_seq(seq);
        end
        idle_on = 1'b1;

        // run cap: 128 copies go out at once, then the run starts afresh
        b = pick_byte();
        seq.delete();
        repeat (130) seq.insert(seq.size(), b);
        seq.insert(seq.size(), b ^ 8'h01);
        send_seq(seq);

        // literal store fills, then an equal byte follows the flushed group
        b = 8'($urandom_range(0, 255));
        seq.delete();
        for (int i = 0; i < pbe_pkg::MAX_LITERAL; i++)
            seq.insert(seq.size(), b + 8'(i * 3));
        seq.insert(seq.size(), seq[seq.size() - 1]);
        seq.insert(seq.size(), seq[seq.size() - 1]);
        seq.insert(seq.size(), b ^ 8'h5a);
        send_seq(seq);

        // store fills on the last word of a stream
        seq.delete();
        for (int i = 0; i < pbe_pkg::MAX_LITERAL; i++)
            seq.insert(seq.size(), 8'(i) ^ 8'hc3);
        send_seq(seq);

        // noise: small alphabet, stray end flags
        for (int i = 0; i < 4; i++)
            alphabet[i] = pick_byte();
        for (int i = 0; i < 40; i++)
            send_word(alphabet[$urandom_range(0, 3)], i == 39 || $urandom_range(11) == 0);

        repeat (2)
        begin
            build_mixed(seq, $urandom_range(10, 20), 12);
            send_seq(seq);
        end

        in_ch.valid <= 1'b0;
        drain();
        repeat (40) @(posedge clk);

        $display("sent %0d input words in %0d streams, checked %0d code words",
                 words_sent, streams_sent, codes_seen);
        $display("runs up to the cap, full literal groups, hold-off and idle-free stretches");
        if (errors == 0 && backlog == 0)
            $display("packbits_encoder regression: pass");
        else
            $display("packbits_encoder regression: fail");
        $finish;
    end

endmodule
